>>> design/ffpa_pkg.sv
package ffpa_pkg;

  localparam int ALIGN_BYTES_DEF     = 8;
  localparam int HEADER_GRANULES_DEF = 2;
  localparam int POOL_GRANULES_DEF   = 4096;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAIL   = 2'd1;
  localparam logic [1:0] ST_IGNORE = 2'd2;

endpackage

>>> design/ffpa_in_if.sv
interface ffpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] size_bytes;
  logic [31:0] address;

  modport source (output valid, mode, size_bytes, address, input ready);
  modport sink (input valid, mode, size_bytes, address, output ready);
endinterface

>>> design/ffpa_out_if.sv
interface ffpa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_address;

  modport source (output valid, status, result_address, input ready);
  modport sink (input valid, status, result_address, output ready);
endinterface

>>> design/first_fit_pool_allocator.sv
// Channel   Dir  Payload
// in_chan   in   mode, size_bytes, address
// out_chan  out  status, result_address
//
// Init runs two divisions, then a sweep that clears the header RAM one entry a
// cycle, then writes the first header. Alloc costs more for each block visited;
// free costs more for each block in the coalescing walk.
// The single-port header RAM sets the per-block cost.
// After reset the same clearing sweep runs, and no item is taken.
// A result waits in the output register; the next item is taken meanwhile.
module first_fit_pool_allocator #(
  parameter int ALIGN_BYTES     = ffpa_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_GRANULES = ffpa_pkg::HEADER_GRANULES_DEF,
  parameter int POOL_GRANULES   = ffpa_pkg::POOL_GRANULES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ffpa_in_if.sink  in_chan,
  ffpa_out_if.source out_chan
);
  import ffpa_pkg::*;

  localparam int AW = $clog2(POOL_GRANULES);
  localparam int SW = $clog2(POOL_GRANULES + 1);
  localparam int CW = SW + 2;
  localparam int RW = $clog2(ALIGN_BYTES) + 1;
  localparam logic [31:0] HBYTES  = 32'(HEADER_GRANULES * ALIGN_BYTES);
  localparam logic [32:0] ALIGN_M1 = 33'(ALIGN_BYTES - 1);
  localparam logic [32:0] ALIGN_W = 33'(ALIGN_BYTES);
  localparam logic [32:0] POOL_W  = 33'(POOL_GRANULES);
  localparam logic [CW-1:0] HDR_C = CW'(HEADER_GRANULES);
  localparam logic [SW-1:0] HDR_S = SW'(HEADER_GRANULES);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_IDIV1, S_IDIV2, S_INIT_WR,
    S_ADIV, S_ARD, S_AEV, S_ASPL,
    S_FCHK, S_FDIV, S_FTAG, S_FTEV,
    S_CRD, S_CEV, S_NCHK, S_NEV, S_CWB, S_DONE
  } state_t;

  state_t        state_r;
  logic [1:0]    mode_r;
  logic [31:0]   size_r, addr_r;
  logic [32:0]   startg_r, need_r;
  logic [SW-1:0] n_r, ninit_r, acc_r, rest_r;
  logic          init_ok_r, ready_r, acc_tag_r;
  logic [31:0]   heap_start_r, heap_end_r;
  logic [CW-1:0] cur_r;
  logic [AW-1:0] clr_idx_r;
  logic          clr_init_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r, res_status_r;
  logic [31:0]   out_addr_r, res_addr_r;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [SW+1:0] mem_wdata, mem_rdata;
  logic [SW-1:0] q_size;
  logic          q_free, q_tag;

  logic          div_start, div_done;
  logic [32:0]   div_dividend, div_quot;
  logic [RW-1:0] div_rem;

  logic [32:0]   top_sum, top_c, ndiff, nsat;
  logic [31:0]   f_hdr, f_off;
  logic          f_ok;
  logic [CW-1:0] a_next, a_split, c_nx;

  assign q_size = mem_rdata[SW+1:2];
  assign q_free = mem_rdata[1];
  assign q_tag  = mem_rdata[0];

  assign top_sum = {1'b0, addr_r} + {1'b0, size_r};
  assign top_c   = top_sum[32] ? 33'h0_FFFF_FFFF : top_sum;
  assign ndiff   = div_quot - startg_r;
  assign nsat    = (ndiff > POOL_W) ? POOL_W : ndiff;

  assign f_hdr = addr_r - HBYTES;
  assign f_off = f_hdr - heap_start_r;
  assign f_ok  = ready_r && addr_r != 32'd0 && addr_r >= HBYTES &&
                 f_hdr >= heap_start_r && addr_r < heap_end_r;

  assign a_next  = cur_r + HDR_C + CW'(q_size);
  assign a_split = cur_r + HDR_C + CW'(need_r[SW-1:0]);
  assign c_nx    = cur_r + HDR_C + CW'(acc_r);

  ffpa_ram #(.WIDTH(SW + 2), .DEPTH(POOL_GRANULES)) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ffpa_div #(.ALIGN_BYTES(ALIGN_BYTES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    mem_we       = 1'b0;
    mem_addr     = cur_r[AW-1:0];
    mem_wdata    = '0;
    div_start    = 1'b0;
    div_dividend = {1'b0, addr_r} + ALIGN_M1;
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_idx_r;
      end
      S_DECODE: begin
        if (mode_r == MODE_INIT) begin
          div_start = 1'b1;
        end else if (mode_r == MODE_ALLOC && ready_r && size_r != 32'd0) begin
          div_start    = 1'b1;
          div_dividend = {1'b0, size_r} + ALIGN_M1;
        end
      end
      S_IDIV1: begin
        div_start    = div_done;
        div_dividend = top_c;
      end
      S_FCHK: begin
        div_start    = f_ok;
        div_dividend = {1'b0, f_off};
      end
      S_INIT_WR: begin
        mem_we    = init_ok_r;
        mem_addr  = '0;
        mem_wdata = {ninit_r - HDR_S, 1'b1, 1'b1};
      end
      S_AEV: begin
        if (q_free && 33'(q_size) >= need_r) begin
          mem_we = 1'b1;
          if (q_size - need_r[SW-1:0] > HDR_S) begin
            mem_wdata = {need_r[SW-1:0], 1'b0, q_tag};
          end else begin
            mem_wdata = {q_size, 1'b0, q_tag};
          end
        end
      end
      S_ASPL: begin
        mem_we    = 1'b1;
        mem_wdata = {rest_r - HDR_S, 1'b1, 1'b1};
      end
      S_FTEV: begin
        mem_we    = q_tag && !q_free;
        mem_wdata = {q_size, 1'b1, q_tag};
      end
      S_NCHK: begin
        mem_addr = c_nx[AW-1:0];
      end
      S_NEV: begin
        mem_we   = q_free;
        mem_addr = c_nx[AW-1:0];
      end
      S_CWB: begin
        mem_we    = 1'b1;
        mem_wdata = {acc_r, 1'b1, acc_tag_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      clr_init_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      ready_r      <= 1'b0;
      n_r          <= '0;
      heap_start_r <= '0;
      heap_end_r   <= '0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (clr_idx_r == AW'(POOL_GRANULES - 1)) begin
            state_r <= clr_init_r ? S_INIT_WR : S_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            mode_r     <= in_chan.mode;
            size_r     <= in_chan.size_bytes;
            addr_r     <= in_chan.address;
            res_addr_r <= '0;
            state_r    <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (mode_r)
            MODE_INIT: state_r <= S_IDIV1;
            MODE_ALLOC: begin
              if (ready_r && size_r != 32'd0) begin
                state_r <= S_ADIV;
              end else begin
                res_status_r <= ST_FAIL;
                state_r      <= S_DONE;
              end
            end
            MODE_FREE: state_r <= S_FCHK;
            default: begin
              res_status_r <= ST_IGNORE;
              state_r      <= S_DONE;
            end
          endcase
        end
        S_IDIV1: begin
          if (div_done) begin
            startg_r <= div_quot;
            state_r  <= S_IDIV2;
          end
        end
        S_IDIV2: begin
          if (div_done) begin
            init_ok_r    <= addr_r != 32'd0 && startg_r < div_quot &&
                            nsat > 33'(HEADER_GRANULES);
            ninit_r      <= SW'(nsat);
            ready_r      <= 1'b0;
            n_r          <= '0;
            heap_start_r <= '0;
            heap_end_r   <= '0;
            clr_idx_r    <= '0;
            clr_init_r   <= 1'b1;
            state_r      <= S_CLEAR;
          end
        end
        S_INIT_WR: begin
          clr_init_r <= 1'b0;
          if (init_ok_r) begin
            heap_start_r <= 32'(startg_r * ALIGN_W);
            heap_end_r   <= 32'((startg_r + 33'(ninit_r)) * ALIGN_W);
            n_r          <= ninit_r;
            ready_r      <= 1'b1;
            res_status_r <= ST_OK;
          end else begin
            res_status_r <= ST_FAIL;
          end
          state_r <= S_DONE;
        end
        S_ADIV: begin
          if (div_done) begin
            need_r  <= div_quot;
            cur_r   <= '0;
            state_r <= S_ARD;
          end
        end
        S_ARD: begin
          if (cur_r >= CW'(n_r)) begin
            res_status_r <= ST_FAIL;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_AEV;
          end
        end
        S_AEV: begin
          if (q_free && 33'(q_size) >= need_r) begin
            res_status_r <= ST_OK;
            res_addr_r   <= heap_start_r +
                            (32'(cur_r) + 32'(HEADER_GRANULES)) * 32'(ALIGN_BYTES);
            rest_r       <= q_size - need_r[SW-1:0];
            cur_r        <= a_split;
            if (q_size - need_r[SW-1:0] > HDR_S && a_split < CW'(n_r)) begin
              state_r <= S_ASPL;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            cur_r   <= a_next;
            state_r <= S_ARD;
          end
        end
        S_ASPL: state_r <= S_DONE;
        S_FCHK: begin
          if (f_ok) begin
            state_r <= S_FDIV;
          end else begin
            res_status_r <= (ready_r && addr_r == 32'd0) ? ST_IGNORE : ST_FAIL;
            state_r      <= S_DONE;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            if (div_rem != '0 || div_quot >= 33'(n_r)) begin
              res_status_r <= ST_FAIL;
              state_r      <= S_DONE;
            end else begin
              cur_r   <= div_quot[CW-1:0];
              state_r <= S_FTAG;
            end
          end
        end
        S_FTAG: state_r <= S_FTEV;
        S_FTEV: begin
          if (q_tag && !q_free) begin
            cur_r   <= '0;
            state_r <= S_CRD;
          end else begin
            res_status_r <= ST_FAIL;
            state_r      <= S_DONE;
          end
        end
        // coalescing walk over the whole chain
        S_CRD: begin
          if (cur_r >= CW'(n_r)) begin
            res_status_r <= ST_OK;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_CEV;
          end
        end
        S_CEV: begin
          if (q_free) begin
            acc_r     <= q_size;
            acc_tag_r <= q_tag;
            state_r   <= S_NCHK;
          end else begin
            cur_r   <= a_next;
            state_r <= S_CRD;
          end
        end
        S_NCHK: state_r <= (c_nx < CW'(n_r)) ? S_NEV : S_CWB;
        S_NEV: begin
          if (q_free) begin
            acc_r   <= acc_r + HDR_S + q_size;
            state_r <= S_NCHK;
          end else begin
            state_r <= S_CWB;
          end
        end
        S_CWB: begin
          cur_r   <= c_nx;
          state_r <= S_CRD;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready           = state_r == S_IDLE;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.result_address = out_addr_r;

  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.result_address != 32'd0 |-> out_chan.status == ST_OK)
    else $error("nonzero result address with failing status");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_IDIV1 || state_r == S_IDIV2 ||
                 state_r == S_ADIV || state_r == S_FDIV)
    else $error("divider finished outside a wait state");

  a_ready_n: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> n_r > HDR_S)
    else $error("usable pool without room for a header");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |=> !(in_chan.valid && in_chan.ready) || $past(clr_idx_r) ==
      AW'(POOL_GRANULES - 1))
    else $error("item accepted during header clear");
endmodule

>>> design/ffpa_ram.sv
module ffpa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/ffpa_div.sv
// Divide by the fixed granule size with a reciprocal multiply, low half of the product first, then the high half.
module ffpa_div #(
  parameter int ALIGN_BYTES = 8,
  localparam int RW = $clog2(ALIGN_BYTES) + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [32:0]   dividend,
  output logic          done,
  output logic [32:0]   quot,
  output logic [RW-1:0] rem
);
  localparam int          LG       = $clog2(ALIGN_BYTES);
  localparam int          SH       = 33 + LG;
  localparam int          PW       = SH + 33;
  localparam logic [33:0] RECIP    = 34'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) /
                                         64'(ALIGN_BYTES));
  localparam logic [16:0] RECIP_LO = RECIP[16:0];
  localparam logic [16:0] RECIP_HI = RECIP[33:17];

  logic [32:0]   num_r;
  logic [49:0]   plo_r;
  logic [32:0]   quot_r;
  logic [1:0]    stage_r;
  logic          done_r;
  logic [49:0]   prod_hi;
  logic [PW-1:0] prod;
  logic [32:0]   back;

  assign prod_hi = {17'd0, num_r} * {33'd0, RECIP_HI};
  assign prod    = PW'(plo_r) + (PW'(prod_hi) << 17);
  assign back    = quot_r * 33'(ALIGN_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[0], start};
      done_r  <= stage_r[1];
      if (start) begin
        num_r <= dividend;
      end
      // low half of the product first, high half and the shift next
      if (stage_r[0]) begin
        plo_r <= {17'd0, num_r} * {33'd0, RECIP_LO};
      end
      if (stage_r[1]) begin
        quot_r <= prod[PW-1:SH];
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = RW'(num_r - back);
endmodule
